// ===== src/hpfp_pkg.sv =====
// Shared types, constants and lookup functions of the headphone payload parser.
package hpfp_pkg;

	// Chunk sizes of the binaural room impulse response section
	localparam int EARLY_CHUNK_BYTES = 12;
	localparam int LATE_CHUNK_BYTES  = 192;

	// Byte queue between the front and the back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Bit step within a byte; the step after the last bit closes the byte
	localparam logic [3:0] STEP_END = 4'd8;

	// Field limits
	localparam logic [3:0] MAX_BANDS = 4'd11;

	// Result kinds
	localparam logic [3:0] KIND_COUNT     = 4'd0;
	localparam logic [3:0] KIND_GAIN      = 4'd1;
	localparam logic [3:0] KIND_LFE_FLAG  = 4'd2;
	localparam logic [3:0] KIND_LFE_GAIN  = 4'd3;
	localparam logic [3:0] KIND_START     = 4'd4;
	localparam logic [3:0] KIND_END       = 4'd5;
	localparam logic [3:0] KIND_BRIR      = 4'd6;
	localparam logic [3:0] KIND_EARLY     = 4'd7;
	localparam logic [3:0] KIND_LATE      = 4'd8;
	localparam logic [3:0] KIND_PARITY    = 4'd9;
	localparam logic [3:0] KIND_DELAYFLAG = 4'd10;
	localparam logic [3:0] KIND_DELAY     = 4'd11;
	localparam logic [3:0] KIND_RTFLAG    = 4'd12;
	localparam logic [3:0] KIND_BANDS     = 4'd13;
	localparam logic [3:0] KIND_RT60      = 4'd14;
	localparam logic [3:0] KIND_STATUS    = 4'd15;

	// Status codes
	localparam logic [2:0] ST_PASS      = 3'd0;
	localparam logic [2:0] ST_TRUNCATED = 3'd1;
	localparam logic [2:0] ST_BAD_COUNT = 3'd2;
	localparam logic [2:0] ST_BAD_BANDS = 3'd3;
	localparam logic [2:0] ST_ZERO_RT60 = 3'd4;
	localparam logic [2:0] ST_PADDING   = 3'd5;

	// Parse phases, one-hot
	typedef enum logic [15:0] {
		PH_COUNT     = 16'h0001,
		PH_GAIN      = 16'h0002,
		PH_LFEFLAG   = 16'h0004,
		PH_LFEGAIN   = 16'h0008,
		PH_START     = 16'h0010,
		PH_END       = 16'h0020,
		PH_BRIR      = 16'h0040,
		PH_EARLY     = 16'h0080,
		PH_LATE      = 16'h0100,
		PH_PARITY    = 16'h0200,
		PH_DELAYFLAG = 16'h0400,
		PH_DELAY     = 16'h0800,
		PH_RTFLAG    = 16'h1000,
		PH_BANDS     = 16'h2000,
		PH_RT60      = 16'h4000,
		PH_PAD       = 16'h8000
	} phase_t;

	// One payload byte as queued
	typedef struct packed {
		logic [7:0] payload_byte;
		logic       last_byte;
	} hpfp_item_t;

	// One result item
	typedef struct packed {
		logic [3:0]  field_kind;
		logic [2:0]  channel_number;
		logic [7:0]  element_index;
		logic [10:0] field_value;
		logic [2:0]  parse_status;
		logic        last_result;
	} hpfp_result_t;

	// Bit width of the field read in a phase
	function automatic logic [3:0] field_width(input phase_t ph);
		logic [3:0] w;
		case (ph)
			PH_COUNT:  w = 4'd3;
			PH_GAIN:   w = 4'd6;
			PH_LFEGAIN: w = 4'd6;
			PH_EARLY:  w = 4'd8;
			PH_LATE:   w = 4'd8;
			PH_PARITY: w = 4'd8;
			PH_DELAY:  w = 4'd11;
			PH_BANDS:  w = 4'd4;
			PH_RT60:   w = 4'd11;
			default:   w = 4'd1;
		endcase
		return w;
	endfunction

	// Result kind of the field read in a phase
	function automatic logic [3:0] field_kind_of(input phase_t ph);
		logic [3:0] k;
		case (ph)
			PH_COUNT:     k = KIND_COUNT;
			PH_GAIN:      k = KIND_GAIN;
			PH_LFEFLAG:   k = KIND_LFE_FLAG;
			PH_LFEGAIN:   k = KIND_LFE_GAIN;
			PH_START:     k = KIND_START;
			PH_END:       k = KIND_END;
			PH_BRIR:      k = KIND_BRIR;
			PH_EARLY:     k = KIND_EARLY;
			PH_LATE:      k = KIND_LATE;
			PH_PARITY:    k = KIND_PARITY;
			PH_DELAYFLAG: k = KIND_DELAYFLAG;
			PH_DELAY:     k = KIND_DELAY;
			PH_RTFLAG:    k = KIND_RTFLAG;
			PH_BANDS:     k = KIND_BANDS;
			PH_RT60:      k = KIND_RT60;
			default:      k = KIND_STATUS;
		endcase
		return k;
	endfunction

endpackage

// ===== src/headphone_payload_field_parser.sv =====
// Top level of the headphone payload field parser: byte queue and bit-serial back end.
//
// Input channel: one payload byte per item (payload_byte, last_byte) on in_valid/in_stall.
// Output channel: one parsed field or status per item on out_valid/out_stall.
// Bytes enter a four-entry queue; the back end walks each byte MSB first, one bit
// per cycle unless the output stalls or a status is pending, then closes the byte in
// a separate step. A field that fails its check is followed by a separate status
// item. Bytes after an error are dropped without their bits being walked. At the
// earliest, a result passes through the queue entry and then the result register,
// when the byte's first bit closes a field; the end status, unless an error was
// reported, is emitted as the last byte is closed. The queue absorbs bursts of up
// to four bytes and takes new bytes while the back end walks earlier ones.
// Reset empties the queue and returns the parser to the channel count field.
// When out_stall is high while a result is held, the result register holds, the
// back end halts and the queue fills; in_stall rises once the queue is full.
module headphone_payload_field_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  payload_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  field_kind,
	output logic [2:0]  channel_number,
	output logic [7:0]  element_index,
	output logic [10:0] field_value,
	output logic [2:0]  parse_status,
	output logic        last_result
);
	import hpfp_pkg::*;

	hpfp_item_t   in_item;
	hpfp_item_t   head;
	logic         head_valid;
	logic         pop;
	hpfp_result_t result;

	assign in_item.payload_byte = payload_byte;
	assign in_item.last_byte    = last_byte;

	hpfp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_item    (in_item),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	hpfp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_result (result)
	);

	assign field_kind     = result.field_kind;
	assign channel_number = result.channel_number;
	assign element_index  = result.element_index;
	assign field_value    = result.field_value;
	assign parse_status   = result.parse_status;
	assign last_result    = result.last_result;

endmodule

// ===== src/hpfp_front.sv =====
// Front of the parser: accepts payload bytes into a short queue for the back.
module hpfp_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  hpfp_pkg::hpfp_item_t in_item,
	output logic                head_valid,
	output hpfp_pkg::hpfp_item_t head,
	input  logic                pop
);
	import hpfp_pkg::*;

	hpfp_item_t        entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	logic              do_pop;

	// Stall only while the queue is full
	assign in_stall   = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign push       = in_valid && !in_stall;
	assign head_valid = (count_q != '0);
	assign head       = entry_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	// Store the accepted item
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= in_item;
		end
	end

	// Advance the pointers and the fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== src/hpfp_back.sv =====
// Back of the parser: walks the bits of each queued byte and emits field results.
module hpfp_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  head_valid,
	input  hpfp_pkg::hpfp_item_t  head,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output hpfp_pkg::hpfp_result_t out_result
);
	import hpfp_pkg::*;

	// Parser state
	phase_t      phase_q,     phase_d;
	logic [10:0] acc_q,       acc_d;
	logic [3:0]  bits_q,      bits_d;
	logic [2:0]  ch_count_q,  ch_count_d;
	logic [7:0]  index_q,     index_d;
	logic [2:0]  chunk_q,     chunk_d;
	logic        flag_start_q, flag_start_d;
	logic        flag_end_q,  flag_end_d;
	logic [3:0]  bands_q,     bands_d;
	logic        drop_q,      drop_d;
	logic [3:0]  step_q,      step_d;
	logic        pend_q,      pend_d;
	logic [2:0]  pend_code_q, pend_code_d;

	// Output register
	logic         out_valid_q;
	hpfp_result_t out_res_q;

	logic         adv;
	logic         emit;
	hpfp_result_t res;
	logic         bit_in;
	logic [10:0]  acc_n;
	logic [3:0]  bits_n;
	logic [2:0]  chunk_inc;
	logic [8:0]  index_inc;
	phase_t      after_brir;
	phase_t      after_parity;

	assign adv        = !out_valid_q || !out_stall;
	assign out_valid  = out_valid_q;
	assign out_result = out_res_q;

	assign bit_in    = head.payload_byte[~step_q[2:0]];
	assign acc_n     = {acc_q[9:0], bit_in};
	assign bits_n    = bits_q + 4'd1;
	assign chunk_inc = chunk_q + 3'd1;
	assign index_inc = {1'b0, index_q} + 9'd1;

	assign after_parity = flag_start_q ? PH_DELAYFLAG : PH_PAD;
	assign after_brir   = flag_end_q ? PH_PARITY : after_parity;

	// Step through the byte: one bit, one pending status or the byte close per cycle when not stalled
	always_comb begin
		phase_d      = phase_q;
		acc_d        = acc_q;
		bits_d       = bits_q;
		ch_count_d   = ch_count_q;
		index_d      = index_q;
		chunk_d      = chunk_q;
		flag_start_d = flag_start_q;
		flag_end_d   = flag_end_q;
		bands_d      = bands_q;
		drop_d       = drop_q;
		step_d       = step_q;
		pend_d       = pend_q;
		pend_code_d  = pend_code_q;
		pop          = 1'b0;
		emit         = 1'b0;
		res          = '0;

		if (head_valid && adv) begin
			if (pend_q) begin
				// Emit the status of an error found on the previous field
				emit             = 1'b1;
				res.field_kind   = KIND_STATUS;
				res.parse_status = pend_code_q;
				res.last_result  = 1'b1;
				pend_d           = 1'b0;
			end else if (step_q == STEP_END) begin
				// Close the byte; on the last byte report the end status unless dropping, and return to reset
				pop    = 1'b1;
				step_d = '0;
				if (head.last_byte) begin
					if (!drop_q) begin
						emit             = 1'b1;
						res.field_kind   = KIND_STATUS;
						res.parse_status = (phase_q == PH_PAD) ? ST_PASS : ST_TRUNCATED;
						res.last_result  = 1'b1;
					end
					phase_d      = PH_COUNT;
					acc_d        = '0;
					bits_d       = '0;
					ch_count_d   = '0;
					index_d      = '0;
					chunk_d      = '0;
					flag_start_d = 1'b0;
					flag_end_d   = 1'b0;
					bands_d      = '0;
					drop_d       = 1'b0;
				end
			end else if (drop_q) begin
				// Drop the rest of the byte
				step_d = STEP_END;
			end else begin
				step_d = step_q + 4'd1;
				if (phase_q == PH_PAD) begin
					// Padding must be zero
					if (bit_in) begin
						emit             = 1'b1;
						res.field_kind   = KIND_STATUS;
						res.parse_status = ST_PADDING;
						res.last_result  = 1'b1;
						drop_d           = 1'b1;
					end
				end else if (bits_n < field_width(phase_q)) begin
					// Collect the bit
					acc_d  = acc_n;
					bits_d = bits_n;
				end else begin
					// Field complete: emit it and pick the next phase
					acc_d           = '0;
					bits_d          = '0;
					emit            = 1'b1;
					res.field_kind  = field_kind_of(phase_q);
					res.field_value = acc_n;
					case (phase_q)
						PH_COUNT: begin
							if (acc_n[2:0] == 3'd0) begin
								pend_d      = 1'b1;
								pend_code_d = ST_BAD_COUNT;
								drop_d      = 1'b1;
							end else begin
								ch_count_d = acc_n[2:0];
								chunk_d    = '0;
								phase_d    = PH_GAIN;
							end
						end
						PH_GAIN: begin
							res.channel_number = chunk_q;
							chunk_d            = chunk_inc;
							if (chunk_inc >= ch_count_q) begin
								phase_d = PH_LFEFLAG;
							end
						end
						PH_LFEFLAG: begin
							phase_d = acc_n[0] ? PH_LFEGAIN : PH_START;
						end
						PH_LFEGAIN: begin
							phase_d = PH_START;
						end
						PH_START: begin
							flag_start_d = acc_n[0];
							phase_d      = PH_END;
						end
						PH_END: begin
							flag_end_d = acc_n[0];
							phase_d    = PH_BRIR;
						end
						PH_BRIR: begin
							if (acc_n[0]) begin
								chunk_d = '0;
								index_d = '0;
								phase_d = PH_EARLY;
							end else begin
								phase_d = after_brir;
							end
						end
						PH_EARLY: begin
							res.channel_number = chunk_q;
							res.element_index  = index_q;
							if (index_inc >= 9'(EARLY_CHUNK_BYTES)) begin
								index_d = '0;
								chunk_d = chunk_inc;
								if (chunk_inc >= ch_count_q) begin
									phase_d = PH_LATE;
								end
							end else begin
								index_d = index_inc[7:0];
							end
						end
						PH_LATE: begin
							res.element_index = index_q;
							if (index_inc >= 9'(LATE_CHUNK_BYTES)) begin
								index_d = '0;
								phase_d = after_brir;
							end else begin
								index_d = index_inc[7:0];
							end
						end
						PH_PARITY: begin
							phase_d = after_parity;
						end
						PH_DELAYFLAG: begin
							if (acc_n[0]) begin
								chunk_d = '0;
								phase_d = PH_DELAY;
							end else begin
								phase_d = PH_RTFLAG;
							end
						end
						PH_DELAY: begin
							res.channel_number = chunk_q;
							chunk_d            = chunk_inc;
							if (chunk_inc >= ch_count_q) begin
								phase_d = PH_RTFLAG;
							end
						end
						PH_RTFLAG: begin
							phase_d = acc_n[0] ? PH_BANDS : PH_PAD;
						end
						PH_BANDS: begin
							if (acc_n[3:0] == 4'd0 || acc_n[3:0] > MAX_BANDS) begin
								pend_d      = 1'b1;
								pend_code_d = ST_BAD_BANDS;
								drop_d      = 1'b1;
							end else begin
								bands_d = acc_n[3:0];
								index_d = '0;
								phase_d = PH_RT60;
							end
						end
						PH_RT60: begin
							res.element_index = index_q;
							if (acc_n == 11'd0) begin
								pend_d      = 1'b1;
								pend_code_d = ST_ZERO_RT60;
								drop_d      = 1'b1;
							end else begin
								index_d = index_inc[7:0];
								if (index_inc >= {5'd0, bands_q}) begin
									phase_d = PH_PAD;
								end
							end
						end
						default: begin
							phase_d = PH_PAD;
						end
					endcase
				end
			end
		end
	end

	// Hold the parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_COUNT;
			acc_q        <= '0;
			bits_q       <= '0;
			ch_count_q   <= '0;
			index_q      <= '0;
			chunk_q      <= '0;
			flag_start_q <= 1'b0;
			flag_end_q   <= 1'b0;
			bands_q      <= '0;
			drop_q       <= 1'b0;
			step_q       <= '0;
			pend_q       <= 1'b0;
			pend_code_q  <= ST_PASS;
			out_valid_q  <= 1'b0;
		end else begin
			phase_q      <= phase_d;
			acc_q        <= acc_d;
			bits_q       <= bits_d;
			ch_count_q   <= ch_count_d;
			index_q      <= index_d;
			chunk_q      <= chunk_d;
			flag_start_q <= flag_start_d;
			flag_end_q   <= flag_end_d;
			bands_q      <= bands_d;
			drop_q       <= drop_d;
			step_q       <= step_d;
			pend_q       <= pend_d;
			pend_code_q  <= pend_code_d;
			if (adv) begin
				out_valid_q <= emit;
			end
		end
	end

	// Load the result register whenever it is free or being taken
	always_ff @(posedge clk) begin
		if (adv) begin
			out_res_q <= res;
		end
	end

endmodule

// ===== verif/headphone_payload_field_parser_tb.sv =====
// Self-checking testbench for the headphone payload field parser.
`timescale 1ns / 1ps

module testbench;
	import hpfp_pkg::*;

	localparam int STUCK_LIMIT   = 2000;
	localparam int RANDOM_ITEMS  = 160;
	localparam int DRAIN_CYCLES  = 100;
	localparam int HOLD_CYCLES   = 80;

	// Presence flag bits
	localparam int FLAG_LFE   = 0;
	localparam int FLAG_START = 1;
	localparam int FLAG_END   = 2;
	localparam int FLAG_BRIR  = 3;
	localparam int FLAG_DELAY = 4;
	localparam int FLAG_RT    = 5;

	// Shape of one generated payload
	typedef struct {
		int count;
		bit has_lfe;
		bit has_start;
		bit has_end;
		bit has_brir;
		bit has_delay;
		bit has_rt;
		int bands;
		int zero_at;
		bit bad_pad;
		int extra_zero;
		int keep_bytes;
		int junk;
	} payload_plan_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  payload_byte = 8'd0;
	logic        last_byte = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [3:0]  field_kind;
	logic [2:0]  channel_number;
	logic [7:0]  element_index;
	logic [10:0] field_value;
	logic [2:0]  parse_status;
	logic        last_result;

	hpfp_item_t   pending_bytes[$];
	hpfp_result_t expected_fields[$];
	bit           payload_bits[$];
	int           failures = 0;
	int           ticks = 0;
	int           stuck = 0;
	int           rx_cycles = 0;
	int           hold_left = 0;
	logic         calm;

	// Parser state as predicted
	phase_t       parse_at;
	logic [10:0]  acc;
	logic [3:0]   acc_bits;
	logic [2:0]   chan_total;
	logic [2:0]   chan_no;
	logic [7:0]   elem_no;
	logic [5:0]   seen_flags;
	logic [3:0]   band_total;
	logic         dropping;

	headphone_payload_field_parser u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.payload_byte(payload_byte),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.field_kind(field_kind),
		.channel_number(channel_number),
		.element_index(element_index),
		.field_value(field_value),
		.parse_status(parse_status),
		.last_result(last_result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	assign calm = (ticks >= 1000) && (ticks < 2200);

	// ---------------------------------------------------------------- predictor

	task automatic clear_parser();
		parse_at   = PH_COUNT;
		acc        = '0;
		acc_bits   = '0;
		chan_total = '0;
		chan_no    = '0;
		elem_no    = '0;
		seen_flags = '0;
		band_total = '0;
		dropping   = 1'b0;
	endtask

	function automatic logic [3:0] field_bits(input phase_t ph);
		case (ph)
			PH_COUNT:                     return 4'd3;
			PH_GAIN, PH_LFEGAIN:          return 4'd6;
			PH_EARLY, PH_LATE, PH_PARITY: return 4'd8;
			PH_BANDS:                     return 4'd4;
			PH_DELAY, PH_RT60:            return 4'd11;
			default:                      return 4'd1;
		endcase
	endfunction

	task automatic expect_field(input logic [3:0] kind, input logic [2:0] ch,
			input logic [7:0] ix, input logic [10:0] val, input logic [2:0] st,
			input logic fin);
		hpfp_result_t r;
		r.field_kind     = kind;
		r.channel_number = ch;
		r.element_index  = ix;
		r.field_value    = val;
		r.parse_status   = st;
		r.last_result    = fin;
		expected_fields.insert(expected_fields.size(), r);
	endtask

	task automatic abort_payload(input logic [2:0] st);
		dropping = 1'b1;
		expect_field(KIND_STATUS, 3'd0, 8'd0, 11'd0, st, 1'b1);
	endtask

	task automatic after_parity();
		parse_at = seen_flags[FLAG_START] ? PH_DELAYFLAG : PH_PAD;
	endtask

	task automatic after_chunks();
		if (seen_flags[FLAG_END])
			parse_at = PH_PARITY;
		else
			after_parity();
	endtask

	// Emit a completed field and advance the phase
	task automatic close_field(input logic [10:0] v);
		case (parse_at)
			PH_COUNT: begin
				expect_field(KIND_COUNT, 3'd0, 8'd0, v, ST_PASS, 1'b0);
				if (v == 11'd0 || v > 11'd7) begin
					abort_payload(ST_BAD_COUNT);
					return;
				end
				chan_total = v[2:0];
				chan_no    = 3'd0;
				parse_at   = PH_GAIN;
			end
			PH_GAIN: begin
				expect_field(KIND_GAIN, chan_no, 8'd0, v, ST_PASS, 1'b0);
				chan_no = chan_no + 3'd1;
				if (chan_no >= chan_total) parse_at = PH_LFEFLAG;
			end
			PH_LFEFLAG: begin
				expect_field(KIND_LFE_FLAG, 3'd0, 8'd0, v, ST_PASS, 1'b0);
				if (v != 11'd0) begin
					seen_flags[FLAG_LFE] = 1'b1;
					parse_at = PH_LFEGAIN;
				end else begin
					parse_at = PH_START;
				end
			end
			PH_LFEGAIN: begin
				expect_field(KIND_LFE_GAIN, 3'd0, 8'd0, v, ST_PASS, 1'b0);
				parse_at = PH_START;
			end
			PH_START: begin
				expect_field(KIND_START, 3'd0, 8'd0, v, ST_PASS, 1'b0);
				if (v != 11'd0) seen_flags[FLAG_START] = 1'b1;
				parse_at = PH_END;
			end
			PH_END: begin
				expect_field(KIND_END, 3'd0, 8'd0, v, ST_PASS, 1'b0);
				if (v != 11'd0) seen_flags[FLAG_END] = 1'b1;
				parse_at = PH_BRIR;
			end
			PH_BRIR: begin
				expect_field(KIND_BRIR, 3'd0, 8'd0, v, ST_PASS, 1'b0);
				if (v != 11'd0) begin
					seen_flags[FLAG_BRIR] = 1'b1;
					chan_no  = 3'd0;
					elem_no  = 8'd0;
					parse_at = PH_EARLY;
				end else begin
					after_chunks();
				end
			end
			PH_EARLY: begin
				expect_field(KIND_EARLY, chan_no, elem_no, v, ST_PASS, 1'b0);
				if (int'(elem_no) + 1 >= EARLY_CHUNK_BYTES) begin
					elem_no = 8'd0;
					chan_no = chan_no + 3'd1;
					if (chan_no >= chan_total) parse_at = PH_LATE;
				end else begin
					elem_no = elem_no + 8'd1;
				end
			end
			PH_LATE: begin
				expect_field(KIND_LATE, 3'd0, elem_no, v, ST_PASS, 1'b0);
				if (int'(elem_no) + 1 >= LATE_CHUNK_BYTES) begin
					elem_no = 8'd0;
					after_chunks();
				end else begin
					elem_no = elem_no + 8'd1;
				end
			end
			PH_PARITY: begin
				expect_field(KIND_PARITY, 3'd0, 8'd0, v, ST_PASS, 1'b0);
				after_parity();
			end
			PH_DELAYFLAG: begin
				expect_field(KIND_DELAYFLAG, 3'd0, 8'd0, v, ST_PASS, 1'b0);
				if (v != 11'd0) begin
					seen_flags[FLAG_DELAY] = 1'b1;
					chan_no  = 3'd0;
					parse_at = PH_DELAY;
				end else begin
					parse_at = PH_RTFLAG;
				end
			end
			PH_DELAY: begin
				expect_field(KIND_DELAY, chan_no, 8'd0, v, ST_PASS, 1'b0);
				chan_no = chan_no + 3'd1;
				if (chan_no >= chan_total) parse_at = PH_RTFLAG;
			end
			PH_RTFLAG: begin
				expect_field(KIND_RTFLAG, 3'd0, 8'd0, v, ST_PASS, 1'b0);
				if (v != 11'd0) begin
					seen_flags[FLAG_RT] = 1'b1;
					parse_at = PH_BANDS;
				end else begin
					parse_at = PH_PAD;
				end
			end
			PH_BANDS: begin
				expect_field(KIND_BANDS, 3'd0, 8'd0, v, ST_PASS, 1'b0);
				if (v == 11'd0 || v > {7'd0, MAX_BANDS}) begin
					abort_payload(ST_BAD_BANDS);
					return;
				end
				band_total = v[3:0];
				elem_no    = 8'd0;
				parse_at   = PH_RT60;
			end
			PH_RT60: begin
				expect_field(KIND_RT60, 3'd0, elem_no, v, ST_PASS, 1'b0);
				if (v == 11'd0) begin
					abort_payload(ST_ZERO_RT60);
					return;
				end
				elem_no = elem_no + 8'd1;
				if (elem_no >= {4'd0, band_total}) parse_at = PH_PAD;
			end
			default: parse_at = PH_PAD;
		endcase
	endtask

	// Walk one accepted byte MSB first and queue the fields it completes
	task automatic predict_fields(input logic [7:0] data, input logic fin);
		logic [10:0] v;
		if (!dropping) begin
			for (int k = 7; k >= 0; k--) begin
				if (parse_at == PH_PAD) begin
					if (data[k]) begin
						abort_payload(ST_PADDING);
						break;
					end
					continue;
				end
				acc      = {acc[9:0], data[k]};
				acc_bits = acc_bits + 4'd1;
				if (acc_bits >= field_bits(parse_at)) begin
					v        = acc;
					acc      = '0;
					acc_bits = '0;
					close_field(v);
					if (dropping) break;
				end
			end
		end
		if (fin) begin
			if (!dropping)
				expect_field(KIND_STATUS, 3'd0, 8'd0, 11'd0,
					(parse_at == PH_PAD) ? ST_PASS : ST_TRUNCATED, 1'b1);
			clear_parser();
		end
	endtask

	// ---------------------------------------------------------------- stimulus

	task automatic put_bits(input int value, input int width);
		for (int i = width - 1; i >= 0; i--)
			payload_bits.insert(payload_bits.size(), 1'((value >> i) & 1));
	endtask

	function automatic int pick_value(input int width);
		int top;
		int r;
		top = (1 << width) - 1;
		r   = $urandom_range(0, 9);
		if (r == 0) return 0;
		if (r == 1) return top;
		return $urandom_range(0, top);
	endfunction

	task automatic queue_raw(input logic [7:0] data, input logic fin);
		hpfp_item_t it;
		it.payload_byte = data;
		it.last_byte    = fin;
		pending_bytes.insert(pending_bytes.size(), it);
	endtask

	function automatic payload_plan_t plain_plan(input int count);
		payload_plan_t p;
		p.count      = count;
		p.has_lfe    = 1'b0;
		p.has_start  = 1'b0;
		p.has_end    = 1'b0;
		p.has_brir   = 1'b0;
		p.has_delay  = 1'b0;
		p.has_rt     = 1'b0;
		p.bands      = 1;
		p.zero_at    = -1;
		p.bad_pad    = 1'b0;
		p.extra_zero = 0;
		p.keep_bytes = 0;
		p.junk       = 0;
		return p;
	endfunction

	function automatic payload_plan_t random_plan(input bit with_brir);
		payload_plan_t p;
		int r;
		p = plain_plan($urandom_range(1, 7));
		r = $urandom_range(0, 99);
		if (r < 4)
			p.count = 0;
		else if (r < 55)
			p.count = $urandom_range(1, 2);
		p.has_lfe   = 1'($urandom_range(0, 1));
		p.has_start = $urandom_range(0, 3) != 0;
		p.has_end   = 1'($urandom_range(0, 1));
		p.has_brir  = with_brir;
		p.has_delay = 1'($urandom_range(0, 1));
		p.has_rt    = $urandom_range(0, 3) != 0;
		r = $urandom_range(0, 99);
		if (r < 5)
			p.bands = 0;
		else if (r < 10)
			p.bands = $urandom_range(12, 15);
		else if (r < 20)
			p.bands = 11;
		else
			p.bands = $urandom_range(1, 4);
		if ($urandom_range(0, 99) < 8 && p.bands >= 1 && p.bands <= 11)
			p.zero_at = $urandom_range(0, p.bands - 1);
		p.bad_pad    = $urandom_range(0, 99) < 10;
		p.extra_zero = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
		if (with_brir)
			p.keep_bytes = $urandom_range(1, 20);
		else if ($urandom_range(0, 99) < 15)
			p.keep_bytes = $urandom_range(1, 6);
		p.junk = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0;
		return p;
	endfunction

	// Serialise a planned payload into bytes and queue them
	task automatic queue_payload(input payload_plan_t p);
		int fields_end;
		int nbytes;
		payload_bits.delete();
		put_bits(p.count, 3);
		if (p.count != 0) begin
			for (int c = 0; c < p.count; c++) put_bits(pick_value(6), 6);
			put_bits(p.has_lfe, 1);
			if (p.has_lfe) put_bits(pick_value(6), 6);
			put_bits(p.has_start, 1);
			put_bits(p.has_end, 1);
			put_bits(p.has_brir, 1);
			if (p.has_brir) begin
				for (int i = 0; i < p.count * EARLY_CHUNK_BYTES; i++)
					put_bits($urandom_range(0, 255), 8);
				for (int i = 0; i < LATE_CHUNK_BYTES; i++)
					put_bits($urandom_range(0, 255), 8);
			end
			if (p.has_end) put_bits(pick_value(8), 8);
			if (p.has_start) begin
				put_bits(p.has_delay, 1);
				if (p.has_delay)
					for (int c = 0; c < p.count; c++) put_bits(pick_value(11), 11);
				put_bits(p.has_rt, 1);
				if (p.has_rt) begin
					put_bits(p.bands, 4);
					if (p.bands >= 1 && p.bands <= 11)
						for (int j = 0; j < p.bands; j++)
							put_bits((j == p.zero_at) ? 0 :
								(($urandom_range(0, 4) == 0) ? 2047 :
								$urandom_range(1, 2047)), 11);
				end
			end
		end
		// pad out to a byte, then any extra zero bytes
		fields_end = payload_bits.size();
		while (payload_bits.size() % 8 != 0)
			payload_bits.insert(payload_bits.size(), 1'b0);
		repeat (p.extra_zero * 8) payload_bits.insert(payload_bits.size(), 1'b0);
		if (p.bad_pad) begin
			if (payload_bits.size() == fields_end)
				repeat (8) payload_bits.insert(payload_bits.size(), 1'b0);
			payload_bits[$urandom_range(fields_end, payload_bits.size() - 1)] = 1'b1;
		end
		nbytes = payload_bits.size() / 8;
		if (p.keep_bytes > 0 && p.keep_bytes < nbytes) nbytes = p.keep_bytes;
		for (int i = 0; i < nbytes; i++)
			queue_raw({payload_bits[8*i], payload_bits[8*i+1], payload_bits[8*i+2],
				payload_bits[8*i+3], payload_bits[8*i+4], payload_bits[8*i+5],
				payload_bits[8*i+6], payload_bits[8*i+7]},
				(i == nbytes - 1) && (p.junk == 0));
		for (int i = 0; i < p.junk; i++)
			queue_raw(8'($urandom_range(0, 255)), i == p.junk - 1);
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin : run_test
		payload_plan_t p;
		int before_fill;
		int random_items;
		int sel;
		int nnoise;
		bit brir_done;

		clear_parser();
		random_items = 0;
		brir_done    = 1'b0;

		// directed: field extremes and each error path
		queue_raw(8'h00, 1'b1);
		queue_raw(8'hFF, 1'b1);
		p = plain_plan(0);
		p.junk = 2;
		queue_payload(p);
		p = plain_plan(1);
		p.has_lfe   = 1'b1;
		p.has_start = 1'b1;
		p.has_end   = 1'b1;
		p.has_delay = 1'b1;
		p.has_rt    = 1'b1;
		queue_payload(p);
		p = plain_plan(1);
		p.has_start = 1'b1;
		p.has_rt    = 1'b1;
		p.bands     = 12;
		queue_payload(p);
		p.bands   = 1;
		p.zero_at = 0;
		queue_payload(p);
		p = plain_plan(1);
		p.bad_pad = 1'b1;
		queue_payload(p);

		// random: mostly well-formed payloads, some chunked, some noise
		while (random_items < RANDOM_ITEMS) begin
			sel = $urandom_range(0, 99);
			before_fill = pending_bytes.size();
			if (!brir_done && random_items >= 60) begin
				p = plain_plan(2);
				p.has_brir  = 1'b1;
				p.has_start = 1'b1;
				p.has_end   = 1'b1;
				p.has_delay = 1'b1;
				p.has_rt    = 1'b1;
				p.bands     = 3;
				queue_payload(p);
				brir_done = 1'b1;
				before_fill = pending_bytes.size();
			end else if (sel < 70) begin
				queue_payload(random_plan(1'b0));
			end else if (sel < 85) begin
				queue_payload(random_plan(1'b1));
			end else begin
				nnoise = $urandom_range(1, 4);
				for (int i = 0; i < nnoise; i++)
					queue_raw(8'($urandom_range(0, 255)), i == nnoise - 1);
			end
			random_items += pending_bytes.size() - before_fill;
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_bytes.size() != 0 || expected_fields.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (failures == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// ---------------------------------------------------------------- driver

	// Offer queued bytes, hold while stalled, rest at random
	always @(posedge clk or negedge arst_n) begin : drive_bytes
		hpfp_item_t cur;
		logic rest;
		if (!arst_n) begin
			in_valid     <= 1'b0;
			payload_byte <= 8'd0;
			last_byte    <= 1'b0;
		end else if (in_valid && in_stall) begin
			in_valid <= 1'b1;
		end else begin
			if (in_valid) begin
				cur = pending_bytes.pop_front();
				predict_fields(cur.payload_byte, cur.last_byte);
			end
			rest = !calm && ($urandom_range(0, 99) < 19);
			if (pending_bytes.size() != 0 && !rest) begin
				in_valid     <= 1'b1;
				payload_byte <= pending_bytes[0].payload_byte;
				last_byte    <= pending_bytes[0].last_byte;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------- monitor

	task automatic check_field(input string name, input logic [10:0] want,
			input logic [10:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			failures++;
		end
	endtask

	// Compare each accepted result with the oldest expectation
	always @(posedge clk or negedge arst_n) begin : watch_results
		hpfp_result_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left <= 0;
			rx_cycles <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_fields.size() == 0) begin
					$error("result with none expected: kind %0d value %0d status %0d",
						field_kind, field_value, parse_status);
					failures++;
				end else begin
					want = expected_fields.pop_front();
					check_field("field_kind", 11'(want.field_kind), 11'(field_kind));
					check_field("channel_number", 11'(want.channel_number),
						11'(channel_number));
					check_field("element_index", 11'(want.element_index),
						11'(element_index));
					check_field("field_value", want.field_value, field_value);
					check_field("parse_status", 11'(want.parse_status),
						11'(parse_status));
					check_field("last_result", 11'(want.last_result), 11'(last_result));
				end
			end
			rx_cycles <= rx_cycles + 1;
			// hold off for a long stretch now and then so the input backs up
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_stall <= 1'b1;
			end else if (rx_cycles % 1500 == 400) begin
				hold_left <= HOLD_CYCLES;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !calm && ($urandom_range(0, 99) < 19);
			end
		end
	end

	// ---------------------------------------------------------------- watchdog

	// Count cycles without any handshake and give up past the limit
	always @(posedge clk) begin
		ticks <= ticks + 1;
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			stuck <= 0;
		else
			stuck <= stuck + 1;
		if (stuck >= STUCK_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

endmodule

// ===== files.f =====
src/hpfp_pkg.sv
src/hpfp_front.sv
src/hpfp_back.sv
src/headphone_payload_field_parser.sv
verif/headphone_payload_field_parser_tb.sv
